>>> rtl/core/pvr_pkg.sv
// ----------------------------------------------------------------------------
// PI voltage regulator package
// Shared widths, reset values, item kinds, register indexes and the
// configuration bundle handed from the register file to the loop.
// ----------------------------------------------------------------------------
package pvr_pkg;

   localparam int FRAC_BITS      = 16;
   localparam int GAIN_W         = 24;
   localparam int MV_W           = 16;
   localparam int CODE_W         = 16;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 24;
   localparam int TARGET_JUMP_MV = 500;

   localparam logic [GAIN_W-1:0] KP_RESET          = 24'd65536;
   localparam logic [GAIN_W-1:0] KI_RESET          = 24'd6554;
   localparam logic [CODE_W-1:0] FLOOR_RESET       = 16'd0;
   localparam logic [CODE_W-1:0] CEILING_RESET     = 16'd4095;
   localparam logic [CODE_W-1:0] BOUND_RESET       = 16'd4095;
   localparam logic              ENABLE_RESET      = 1'b0;
   localparam logic [MV_W-1:0]   TOLERANCE_RESET   = 16'd50;
   localparam logic [MV_W-1:0]   TARGET_CEIL_RESET = 16'd3300;

   typedef enum logic [1:0] {
      KIND_MEASURE    = 2'd0,
      KIND_SET_TARGET = 2'd1,
      KIND_RESET_LOOP = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_KP          = 3'd0,
      REG_KI          = 3'd1,
      REG_FLOOR       = 3'd2,
      REG_CEILING     = 3'd3,
      REG_BOUND       = 3'd4,
      REG_ENABLE      = 3'd5,
      REG_TOLERANCE   = 3'd6,
      REG_TARGET_CEIL = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0] kp;
      logic [GAIN_W-1:0] ki;
      logic [CODE_W-1:0] floor_code;
      logic [CODE_W-1:0] ceiling_code;
      logic [CODE_W-1:0] bound;
      logic              enable;
      logic [MV_W-1:0]   tolerance;
      logic [MV_W-1:0]   target_ceil;
      logic              clear_acc;
   } cfg_type;

endpackage

>>> rtl/core/pi_voltage_regulator.sv
// ----------------------------------------------------------------------------
// PI voltage regulator
// One-channel PI loop with anti-windup that turns voltage samples into a
// drive code.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while results are taken, and returns
// exactly one result item for each, in order. An accepted item lands in an
// input register; once the result register is free or being emptied, the PI
// update (two gain multiplies, the integrator clamp, the output clamp and the
// anti-windup undo) runs in one pass of logic, writes the loop state and loads
// the result register. Throughput is one item per cycle while rsp_ready holds,
// set by that single update pass, which also closes the integrator feedback.
// The result register decouples the two sides: while a result waits for
// rsp_ready, the block still takes one further item into its input register.
// Configuration registers are written through the csr_ port, which never
// stalls; a write to either gain clears the integrator. Write configuration
// only while no item is in flight.

module pi_voltage_regulator #(
   parameter int FRAC_BITS = pvr_pkg::FRAC_BITS
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_kind,
   input  logic [pvr_pkg::MV_W-1:0]          req_millivolts,
   input  logic                              req_short_fault,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [pvr_pkg::CODE_W-1:0]        rsp_drive_code,
   output logic                              rsp_stable,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pvr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pvr_pkg::CSR_DATA_W-1:0]    csr_data
);

   pvr_pkg::cfg_type cfg;

   // Input register.
   logic                       in_valid_ff, in_valid_in;
   logic [1:0]                 in_kind_ff;
   logic [pvr_pkg::MV_W-1:0]   in_mv_ff;
   logic                       in_fault_ff;

   // Result register.
   logic                       out_valid_ff, out_valid_in;
   logic [pvr_pkg::CODE_W-1:0] out_code_ff;
   logic                       out_stable_ff;

   logic                       req_take;
   logic                       advance;
   logic [pvr_pkg::CODE_W-1:0] next_code;
   logic                       next_stable;

   // The item in the input register moves on when the result register is free
   // or is being emptied in the same cycle.
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign req_take     = req_valid && req_ready;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);
   assign csr_ready    = 1'b1;

   pvr_csr u_pvr_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pvr_loop #(
      .FRAC_BITS (FRAC_BITS)
   ) u_pvr_loop (
      .clock       (clock),
      .reset       (reset),
      .fire        (advance),
      .kind        (in_kind_ff),
      .millivolts  (in_mv_ff),
      .short_fault (in_fault_ff),
      .cfg         (cfg),
      .drive_code  (next_code),
      .stable      (next_stable)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff  <= req_kind;
         in_mv_ff    <= req_millivolts;
         in_fault_ff <= req_short_fault;
      end
      if (advance) begin
         out_code_ff   <= next_code;
         out_stable_ff <= next_stable;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_drive_code = out_code_ff;
   assign rsp_stable     = out_stable_ff;

endmodule

>>> rtl/core/pvr_csr.sv
// ----------------------------------------------------------------------------
// PI voltage regulator register file
// Holds the eight configuration registers and flags gain writes, which
// clear the integrator.
// ----------------------------------------------------------------------------
module pvr_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   input  logic [pvr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pvr_pkg::CSR_DATA_W-1:0]    csr_data,
   output pvr_pkg::cfg_type                  cfg
);

   logic [pvr_pkg::GAIN_W-1:0] kp_ff;
   logic [pvr_pkg::GAIN_W-1:0] ki_ff;
   logic [pvr_pkg::CODE_W-1:0] floor_ff;
   logic [pvr_pkg::CODE_W-1:0] ceiling_ff;
   logic [pvr_pkg::CODE_W-1:0] bound_ff;
   logic                       enable_ff;
   logic [pvr_pkg::MV_W-1:0]   tolerance_ff;
   logic [pvr_pkg::MV_W-1:0]   target_ceil_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff          <= pvr_pkg::KP_RESET;
         ki_ff          <= pvr_pkg::KI_RESET;
         floor_ff       <= pvr_pkg::FLOOR_RESET;
         ceiling_ff     <= pvr_pkg::CEILING_RESET;
         bound_ff       <= pvr_pkg::BOUND_RESET;
         enable_ff      <= pvr_pkg::ENABLE_RESET;
         tolerance_ff   <= pvr_pkg::TOLERANCE_RESET;
         target_ceil_ff <= pvr_pkg::TARGET_CEIL_RESET;
      end else if (csr_valid) begin
         unique case (pvr_pkg::csr_index_type'(csr_index))
            pvr_pkg::REG_KP:          kp_ff          <= csr_data;
            pvr_pkg::REG_KI:          ki_ff          <= csr_data;
            pvr_pkg::REG_FLOOR:       floor_ff       <= csr_data[pvr_pkg::CODE_W-1:0];
            pvr_pkg::REG_CEILING:     ceiling_ff     <= csr_data[pvr_pkg::CODE_W-1:0];
            pvr_pkg::REG_BOUND:       bound_ff       <= csr_data[pvr_pkg::CODE_W-1:0];
            pvr_pkg::REG_ENABLE:      enable_ff      <= csr_data[0];
            pvr_pkg::REG_TOLERANCE:   tolerance_ff   <= csr_data[pvr_pkg::MV_W-1:0];
            pvr_pkg::REG_TARGET_CEIL: target_ceil_ff <= csr_data[pvr_pkg::MV_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.kp           = kp_ff;
      cfg.ki           = ki_ff;
      cfg.floor_code   = floor_ff;
      cfg.ceiling_code = ceiling_ff;
      cfg.bound        = bound_ff;
      cfg.enable       = enable_ff;
      cfg.tolerance    = tolerance_ff;
      cfg.target_ceil  = target_ceil_ff;
      cfg.clear_acc    = csr_valid &&
                         (csr_index == pvr_pkg::REG_KP || csr_index == pvr_pkg::REG_KI);
   end

endmodule

>>> rtl/core/pvr_loop.sv
// ----------------------------------------------------------------------------
// PI voltage regulator loop
// Control state and the combinational PI update: error, both gain products,
// integrator clamp, output clamp, anti-windup undo and the stable flag.
// ----------------------------------------------------------------------------
module pvr_loop #(
   parameter int FRAC_BITS = pvr_pkg::FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  logic [1:0]                    kind,
   input  logic [pvr_pkg::MV_W-1:0]      millivolts,
   input  logic                          short_fault,
   input  pvr_pkg::cfg_type              cfg,
   output logic [pvr_pkg::CODE_W-1:0]    drive_code,
   output logic                          stable
);

   localparam int MV_W   = pvr_pkg::MV_W;
   localparam int CODE_W = pvr_pkg::CODE_W;
   localparam int PROD_W = pvr_pkg::GAIN_W + MV_W + 2;
   localparam int BND_W  = CODE_W + FRAC_BITS + 1;
   // Headroom: after an undo the accumulator may sit one increment past the bound.
   localparam int ACC_W  = ((PROD_W > BND_W) ? PROD_W : BND_W) + 2;
   localparam int SUM_W  = ACC_W + 1;
   localparam int PAD_A  = ACC_W - CODE_W - FRAC_BITS;
   localparam int PAD_S  = SUM_W - CODE_W - FRAC_BITS;
   localparam logic signed [MV_W:0] JUMP = (MV_W+1)'(pvr_pkg::TARGET_JUMP_MV);

   logic [MV_W-1:0]         target_ff, target_in;
   logic [MV_W-1:0]         measured_ff, measured_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [CODE_W-1:0]       held_ff, held_in;

   logic signed [MV_W:0]     err;
   logic signed [PROD_W-1:0] p_term, inc;
   logic signed [ACC_W-1:0]  bnd, acc_add, acc_clamped, acc_meas;
   logic signed [SUM_W-1:0]  hi, lo, sum, sum_clamped;
   logic                     undo;
   logic [MV_W-1:0]          target_sat;
   logic signed [MV_W:0]     jump_diff, stab_diff;
   logic [MV_W:0]            stab_abs;

   // PI datapath for a measurement item.
   always_comb begin
      err     = $signed({1'b0, target_ff}) - $signed({1'b0, millivolts});
      p_term  = $signed({1'b0, cfg.kp}) * err;
      inc     = $signed({1'b0, cfg.ki}) * err;

      bnd     = $signed({{PAD_A{1'b0}}, cfg.bound, {FRAC_BITS{1'b0}}});
      acc_add = acc_ff + ACC_W'(inc);
      if (acc_add > bnd) begin
         acc_clamped = bnd;
      end else if (acc_add < -bnd) begin
         acc_clamped = -bnd;
      end else begin
         acc_clamped = acc_add;
      end

      hi  = $signed({{PAD_S{1'b0}}, cfg.ceiling_code, {FRAC_BITS{1'b0}}});
      lo  = $signed({{PAD_S{1'b0}}, cfg.floor_code, {FRAC_BITS{1'b0}}});
      sum = SUM_W'(p_term) + SUM_W'(acc_clamped);
      // Ceiling is tested first, so a floor above the ceiling still yields a limit.
      if (sum > hi) begin
         sum_clamped = hi;
      end else if (sum < lo) begin
         sum_clamped = lo;
      end else begin
         sum_clamped = sum;
      end

      undo     = (err > 0 && sum_clamped >= hi) || (err < 0 && sum_clamped <= lo);
      acc_meas = undo ? (acc_clamped - ACC_W'(inc)) : acc_clamped;
   end

   // Next state per item kind.
   always_comb begin
      target_in   = target_ff;
      measured_in = measured_ff;
      acc_in      = acc_ff;
      held_in     = held_ff;
      target_sat  = (millivolts > cfg.target_ceil) ? cfg.target_ceil : millivolts;
      jump_diff   = $signed({1'b0, target_sat}) - $signed({1'b0, measured_ff});
      unique case (kind)
         pvr_pkg::KIND_MEASURE: begin
            measured_in = millivolts;
            if (!cfg.enable || short_fault) begin
               acc_in  = '0;
               held_in = '0;
            end else begin
               acc_in  = acc_meas;
               held_in = sum_clamped[FRAC_BITS +: CODE_W];
            end
         end
         pvr_pkg::KIND_SET_TARGET: begin
            target_in = target_sat;
            if (jump_diff > JUMP || jump_diff < -JUMP) begin
               acc_in = '0;
            end
         end
         pvr_pkg::KIND_RESET_LOOP: begin
            acc_in  = '0;
            held_in = '0;
         end
         default: ;
      endcase

      stab_diff  = $signed({1'b0, target_in}) - $signed({1'b0, measured_in});
      stab_abs   = stab_diff[MV_W] ? unsigned'(-stab_diff) : unsigned'(stab_diff);
      stable     = cfg.enable && (stab_abs <= {1'b0, cfg.tolerance});
      drive_code = held_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff   <= '0;
         measured_ff <= '0;
         acc_ff      <= '0;
         held_ff     <= '0;
      end else begin
         if (fire) begin
            target_ff   <= target_in;
            measured_ff <= measured_in;
            held_ff     <= held_in;
         end
         if (cfg.clear_acc) begin
            acc_ff <= '0;
         end else if (fire) begin
            acc_ff <= acc_in;
         end
      end
   end

endmodule

>>> rtl/core/pvr_checker.sv
// ----------------------------------------------------------------------------
// PI voltage regulator checker
// Port-level checks on item flow through the regulator, bound to the top.
// ----------------------------------------------------------------------------
module pvr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [pvr_pkg::CODE_W-1:0]    rsp_drive_code,
   input logic                          rsp_stable
);

   // Items accepted but whose results are not yet taken.
   logic [1:0] pending_ff, pending_in;

   assign pending_in = pending_ff + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_drive_code) && $stable(rsp_stable))
      else $error("result changed or dropped while stalled");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("result shown without an accepted item");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more items in flight than the two registers hold");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 2'd0 |-> req_ready)
      else $error("input stalled while the block is empty");

endmodule

bind pi_voltage_regulator pvr_checker u_pvr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_drive_code (rsp_drive_code),
   .rsp_stable     (rsp_stable)
);

>>> tb/sv/pi_voltage_regulator_tb.sv
// ----------------------------------------------------------------------------
// PI voltage regulator testbench
// Drives measurement, target and loop-reset items through the regulator under
// several register settings and idle patterns. A local model of the PI loop
// predicts each drive code and stable flag, which are checked in order.
// ----------------------------------------------------------------------------

module pi_voltage_regulator_tb;

   // One input item as it sits on the req_ ports.
   typedef struct packed {
      logic [1:0]               kind;
      logic [pvr_pkg::MV_W-1:0] mv;
      logic                     fault;
   } sample_type;

   // One result item as it appears on the rsp_ ports.
   typedef struct packed {
      logic [pvr_pkg::CODE_W-1:0] code;
      logic                       stable;
   } drive_result_type;

   // The package names only the three defined kinds; the fourth code must
   // leave the loop untouched.
   localparam logic [1:0] KIND_UNUSED      = 2'd3;
   localparam int         CYCLE_LIMIT      = 400000;
   localparam int         LONG_HOLD_CYCLES = 400;
   localparam int         SETTLE_CYCLES    = 8;
   localparam int         PHASE_ITEMS      = 260;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;

   logic                           req_valid       = 1'b0;
   logic                           req_ready;
   logic [1:0]                     req_kind        = '0;
   logic [pvr_pkg::MV_W-1:0]       req_millivolts  = '0;
   logic                           req_short_fault = 1'b0;

   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [pvr_pkg::CODE_W-1:0]     rsp_drive_code;
   logic                           rsp_stable;

   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [pvr_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [pvr_pkg::CSR_DATA_W-1:0] csr_data  = '0;

   // Local copy of the register file, starting from the reset values.
   logic [pvr_pkg::GAIN_W-1:0]     kp_reg    = pvr_pkg::KP_RESET;
   logic [pvr_pkg::GAIN_W-1:0]     ki_reg    = pvr_pkg::KI_RESET;
   logic [pvr_pkg::CODE_W-1:0]     floor_reg = pvr_pkg::FLOOR_RESET;
   logic [pvr_pkg::CODE_W-1:0]     ceil_reg  = pvr_pkg::CEILING_RESET;
   logic [pvr_pkg::CODE_W-1:0]     bound_reg = pvr_pkg::BOUND_RESET;
   logic                           en_reg    = pvr_pkg::ENABLE_RESET;
   logic [pvr_pkg::MV_W-1:0]       tol_reg   = pvr_pkg::TOLERANCE_RESET;
   logic [pvr_pkg::MV_W-1:0]       tceil_reg = pvr_pkg::TARGET_CEIL_RESET;

   // Local copy of the loop state. The integrator is held far wider than the
   // hardware needs so that the undo step can never wrap.
   logic [pvr_pkg::MV_W-1:0]       setpoint_mv = '0;
   logic [pvr_pkg::MV_W-1:0]       last_mv     = '0;
   longint                         acc         = 0;
   logic [pvr_pkg::CODE_W-1:0]     held        = '0;

   sample_type                     sample_queue[$];
   drive_result_type               predicted_outputs[$];
   sample_type                     offered;
   logic                           item_offered = 1'b0;
   drive_result_type               awaited;

   logic [pvr_pkg::MV_W-1:0]       aim_mv = '0;
   int                             sender_idle_pct    = 0;
   int                             receiver_stall_pct = 0;
   logic                           long_hold_wanted   = 1'b0;
   logic                           long_hold_done     = 1'b0;
   int                             hold_left          = 0;
   int                             mismatches         = 0;
   int                             cycles             = 0;

   pi_voltage_regulator i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_millivolts  (req_millivolts),
      .req_short_fault (req_short_fault),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_drive_code  (rsp_drive_code),
      .rsp_stable      (rsp_stable),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #2 clock = ~clock;

   // Advance the local loop by one accepted item and return the result that
   // the block must produce for it. Every item yields exactly one result.
   function automatic drive_result_type pi_update(input sample_type s);
      longint                   err;
      longint                   p_term;
      longint                   inc;
      longint                   sum;
      longint                   hi;
      longint                   lo;
      longint                   bnd;
      longint                   gap;
      logic [pvr_pkg::MV_W-1:0] mv;
      drive_result_type         r;
      mv = s.mv;
      case (s.kind)
         pvr_pkg::KIND_MEASURE: begin
            last_mv = mv;
            if (!en_reg || s.fault) begin
               // A disabled or faulted channel drops the drive and the
               // integrator at once.
               held = '0;
               acc  = 0;
            end else begin
               err    = longint'(setpoint_mv) - longint'(mv);
               p_term = longint'(kp_reg) * err;
               inc    = longint'(ki_reg) * err;
               bnd    = longint'(bound_reg) <<< pvr_pkg::FRAC_BITS;
               acc    = acc + inc;
               if (acc > bnd) begin
                  acc = bnd;
               end else if (acc < -bnd) begin
                  acc = -bnd;
               end
               // The ceiling is tested first, so with the floor above the
               // ceiling the code is always one of the two limits.
               hi  = longint'(ceil_reg) <<< pvr_pkg::FRAC_BITS;
               lo  = longint'(floor_reg) <<< pvr_pkg::FRAC_BITS;
               sum = p_term + acc;
               if (sum > hi) begin
                  sum = hi;
               end else if (sum < lo) begin
                  sum = lo;
               end
               // Anti-windup: back out this step's integration when the output
               // is pinned at the rail the error pushes toward. This acts on
               // the clamped integrator, so it may leave the bound for a while.
               if ((err > 0 && sum >= hi) || (err < 0 && sum <= lo)) begin
                  acc = acc - inc;
               end
               held = sum[pvr_pkg::FRAC_BITS +: pvr_pkg::CODE_W];
            end
         end
         pvr_pkg::KIND_SET_TARGET: begin
            if (mv > tceil_reg) begin
               mv = tceil_reg;
            end
            setpoint_mv = mv;
            gap = longint'(mv) - longint'(last_mv);
            if (gap > pvr_pkg::TARGET_JUMP_MV || gap < -pvr_pkg::TARGET_JUMP_MV) begin
               acc = 0;
            end
         end
         pvr_pkg::KIND_RESET_LOOP: begin
            acc  = 0;
            held = '0;
         end
         default: begin
         end
      endcase
      // The stable flag always reflects the state after the item.
      gap = longint'(setpoint_mv) - longint'(last_mv);
      if (gap < 0) begin
         gap = -gap;
      end
      r.code   = held;
      r.stable = en_reg && (gap <= longint'(tol_reg));
      return r;
   endfunction

   function automatic logic [pvr_pkg::MV_W-1:0] clip_mv(input int v);
      if (v < 0) begin
         return '0;
      end
      if (v > 65535) begin
         return '1;
      end
      return 16'(v);
   endfunction

   // Random items are mostly samples close to the current target, so that
   // the integrator settles and the stable flag toggles, with wild samples,
   // target moves, faults and loop resets mixed in.
   function automatic sample_type next_random_sample();
      sample_type s;
      int         pick;
      pick    = $urandom_range(99);
      s.fault = 1'($urandom);
      s.mv    = 16'($urandom);
      if (pick < 78) begin
         s.kind  = pvr_pkg::KIND_MEASURE;
         s.fault = ($urandom_range(99) < 6);
         pick    = $urandom_range(99);
         if (pick < 60) begin
            s.mv = clip_mv(int'(aim_mv) + int'($urandom_range(0, 240)) - 120);
         end else if (pick < 80) begin
            s.mv = clip_mv(int'(aim_mv) + int'($urandom_range(0, 1200)) - 600);
         end
      end else if (pick < 90) begin
         s.kind = pvr_pkg::KIND_SET_TARGET;
         pick   = $urandom_range(99);
         if (pick < 60) begin
            s.mv = clip_mv(int'(aim_mv) + int'($urandom_range(0, 800)) - 400);
         end else if (pick < 85) begin
            s.mv = 16'($urandom_range(0, tceil_reg));
         end
         aim_mv = (s.mv > tceil_reg) ? tceil_reg : s.mv;
      end else if (pick < 96) begin
         s.kind = pvr_pkg::KIND_RESET_LOOP;
      end else begin
         s.kind = KIND_UNUSED;
      end
      return s;
   endfunction

   task automatic queue_sample(input logic [1:0] kind,
                               input logic [pvr_pkg::MV_W-1:0] mv,
                               input logic fault);
      sample_type s;
      s.kind  = kind;
      s.mv    = mv;
      s.fault = fault;
      sample_queue.push_back(s);
   endtask

   // Wait until no item is queued, offered or in flight, then let the block
   // settle. Each item produces a result, so the settle time is only margin.
   task automatic drain();
      while (sample_queue.size() != 0 || item_offered || predicted_outputs.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register and mirror it in the local model at the handshake.
   // The caller lowers csr_valid after the last write of a batch, so that
   // back-to-back writes never lower and raise the valid in one time step.
   task automatic write_setting(input pvr_pkg::csr_index_type idx,
                                input logic [pvr_pkg::CSR_DATA_W-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         pvr_pkg::REG_KP: begin
            kp_reg = value;
            acc    = 0;
         end
         pvr_pkg::REG_KI: begin
            ki_reg = value;
            acc    = 0;
         end
         pvr_pkg::REG_FLOOR:       floor_reg = value[pvr_pkg::CODE_W-1:0];
         pvr_pkg::REG_CEILING:     ceil_reg  = value[pvr_pkg::CODE_W-1:0];
         pvr_pkg::REG_BOUND:       bound_reg = value[pvr_pkg::CODE_W-1:0];
         pvr_pkg::REG_ENABLE:      en_reg    = value[0];
         pvr_pkg::REG_TOLERANCE:   tol_reg   = value[pvr_pkg::MV_W-1:0];
         pvr_pkg::REG_TARGET_CEIL: tceil_reg = value[pvr_pkg::MV_W-1:0];
         default: begin
         end
      endcase
   endtask

   // Program all eight registers. The unused upper data bits of the narrow
   // registers carry random junk, which the block must ignore.
   task automatic program_loop(input logic [pvr_pkg::GAIN_W-1:0] kp_val, ki_val,
                               input logic [pvr_pkg::CODE_W-1:0] floor_val, ceil_val,
                                                                 bound_val,
                               input logic en_val,
                               input logic [pvr_pkg::MV_W-1:0] tol_val, tceil_val);
      write_setting(pvr_pkg::REG_KP, kp_val);
      write_setting(pvr_pkg::REG_KI, ki_val);
      write_setting(pvr_pkg::REG_FLOOR, {8'($urandom), floor_val});
      write_setting(pvr_pkg::REG_CEILING, {8'($urandom), ceil_val});
      write_setting(pvr_pkg::REG_BOUND, {8'($urandom), bound_val});
      write_setting(pvr_pkg::REG_TOLERANCE, {8'($urandom), tol_val});
      write_setting(pvr_pkg::REG_TARGET_CEIL, {8'($urandom), tceil_val});
      write_setting(pvr_pkg::REG_ENABLE, {23'($urandom), en_val});
      csr_valid <= 1'b0;
      aim_mv = setpoint_mv;
   endtask

   // Random items, with a pause halfway in which the sender waits until every
   // result has come back.
   task automatic run_random(input int count);
      for (int n = 0; n < count; n++) begin
         if (n == count / 2) begin
            drain();
         end
         sample_queue.push_back(next_random_sample());
      end
      drain();
   endtask

   // Sender: presents queued items, holding each one steady until it is
   // taken. The prediction is made at the edge where the item is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_outputs.push_back(pi_update(offered));
         end
         if (!req_valid || req_ready) begin
            if (sample_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               offered          = sample_queue.pop_front();
               item_offered     = 1'b1;
               req_valid       <= 1'b1;
               req_kind        <= offered.kind;
               req_millivolts  <= offered.mv;
               req_short_fault <= offered.fault;
            end else begin
               item_offered = 1'b0;
               req_valid   <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each result against the oldest prediction and drives
   // rsp_ready, including one long hold-off that fills the block up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_outputs.size() == 0) begin
               $display("%0t: result with nothing predicted: drive_code %0d stable %0b",
                        $time, rsp_drive_code, rsp_stable);
               mismatches++;
            end else begin
               awaited = predicted_outputs.pop_front();
               if (rsp_drive_code !== awaited.code) begin
                  $display("%0t: drive_code expected %0d actual %0d",
                           $time, awaited.code, rsp_drive_code);
                  mismatches++;
               end
               if (rsp_stable !== awaited.stable) begin
                  $display("%0t: stable expected %0b actual %0b",
                           $time, awaited.stable, rsp_stable);
                  mismatches++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (long_hold_wanted && !long_hold_done) begin
            hold_left      = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
            rsp_ready     <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // Watchdog: a stuck handshake ends the run as a failure.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("pi_voltage_regulator test failed");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // With the reset settings the channel is disabled: the drive stays at
      // zero and the stable flag stays low whatever the error.
      queue_sample(pvr_pkg::KIND_MEASURE, 16'd1200, 1'b0);
      queue_sample(pvr_pkg::KIND_SET_TARGET, 16'd1200, 1'b0);
      drain();

      write_setting(pvr_pkg::REG_ENABLE, 24'd1);
      csr_valid <= 1'b0;
      // Target equal to the last sample, then samples at and just past the
      // stable tolerance.
      queue_sample(pvr_pkg::KIND_SET_TARGET, 16'd1200, 1'b0);
      queue_sample(pvr_pkg::KIND_MEASURE, 16'd1250, 1'b0);
      queue_sample(pvr_pkg::KIND_MEASURE, 16'd1251, 1'b0);
      queue_sample(pvr_pkg::KIND_MEASURE, 16'd1200, 1'b0);
      queue_sample(pvr_pkg::KIND_MEASURE, 16'd1000, 1'b0);
      // A target above the ceiling saturates, and the jump clears the
      // integrator. Repeated zero samples then drive the output into the
      // ceiling, where the undo step kicks in.
      queue_sample(pvr_pkg::KIND_SET_TARGET, 16'hFFFF, 1'b0);
      repeat (6) queue_sample(pvr_pkg::KIND_MEASURE, 16'd0, 1'b0);
      // Full-scale samples slam the output into the floor.
      queue_sample(pvr_pkg::KIND_MEASURE, 16'hFFFF, 1'b0);
      queue_sample(pvr_pkg::KIND_MEASURE, 16'hFFFF, 1'b0);
      // A faulted sample zeroes the drive; the fault flag is ignored on
      // other kinds.
      queue_sample(pvr_pkg::KIND_MEASURE, 16'd3300, 1'b1);
      queue_sample(pvr_pkg::KIND_SET_TARGET, 16'd3000, 1'b1);
      queue_sample(pvr_pkg::KIND_MEASURE, 16'd2990, 1'b0);
      queue_sample(pvr_pkg::KIND_RESET_LOOP, 16'hFFFF, 1'b1);
      queue_sample(KIND_UNUSED, 16'hFFFF, 1'b1);
      queue_sample(pvr_pkg::KIND_SET_TARGET, 16'd0, 1'b0);
      queue_sample(pvr_pkg::KIND_MEASURE, 16'd0, 1'b0);
      queue_sample(pvr_pkg::KIND_MEASURE, 16'hFFFF, 1'b0);
      drain();

      // Reset-like tuning with no idling on either side.
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      program_loop(pvr_pkg::KP_RESET, pvr_pkg::KI_RESET, 16'd0, 16'd4095, 16'd4095,
                   1'b1, 16'd50, 16'd3300);
      run_random(PHASE_ITEMS);

      // Random moderate tuning; the sender idles often.
      sender_idle_pct = 63;
      program_loop(24'($urandom_range(0, 262143)), 24'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 500)), 16'($urandom_range(1000, 65535)),
                   16'($urandom), 1'b1, 16'($urandom_range(0, 200)),
                   16'($urandom_range(1000, 65535)));
      run_random(PHASE_ITEMS);

      // Every register but the floor (zero) at maximum; the receiver stalls
      // often and once for long, so the block backs up into its input.
      sender_idle_pct    = 0;
      receiver_stall_pct = 63;
      program_loop('1, '1, '0, '1, '1, 1'b1, '1, '1);
      long_hold_wanted = 1'b1;
      run_random(PHASE_ITEMS);

      // Zero gains, zero bound, zero tolerance and a floor above the ceiling.
      sender_idle_pct    = 31;
      receiver_stall_pct = 31;
      program_loop('0, '0, '1, '0, '0, 1'b1, '0, '0);
      run_random(PHASE_ITEMS);

      // Fully random settings, the enable included.
      program_loop(24'($urandom), 24'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
      run_random(PHASE_ITEMS);

      // Channel disabled under otherwise sensible tuning, no idling.
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      program_loop(24'($urandom_range(0, 131072)), 24'($urandom_range(0, 16384)),
                   16'd100, 16'd4000, 16'd2000, 1'b0, 16'd100, 16'd3300);
      run_random(PHASE_ITEMS);

      if (mismatches == 0) begin
         $display("pi_voltage_regulator test passed");
      end else begin
         $display("pi_voltage_regulator test failed");
      end
      $finish;
   end

endmodule
